/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files, included by the scheduler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a implies b at every clock edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// check that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* hw/rtl/ttns_pkg.sv */
// shared types and codes for the task table scheduler
package ttns_pkg;
  localparam int unsigned META_WIDTH = 18;
  localparam logic [2:0] OP_SCHEDULE = 3'd0;
  localparam logic [2:0] OP_POP = 3'd1;
  localparam logic [2:0] OP_LINK_UP = 3'd2;
  localparam logic [2:0] OP_LINK_DOWN = 3'd3;
  localparam logic [2:0] OP_TIMER = 3'd4;
  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_FULL = 3'd1;
  localparam logic [2:0] KIND_ISSUED = 3'd2;
  localparam logic [2:0] KIND_NOT_READY = 3'd3;
  localparam logic [2:0] KIND_PENDING = 3'd4;
  localparam logic [2:0] KIND_DROPPED = 3'd5;
  localparam logic [2:0] KIND_NO_EFFECT = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // control from the sequencer into the cell row
  typedef struct packed {
    logic load;
    logic shift;
    logic remove;
  } cell_ctrl_t;
endpackage

/* hw/rtl/ttns_if.sv */
// valid/ready channel interfaces for commands and results
interface ttns_in_if #(parameter int TW = 48) ();
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [7:0] task_id;
  logic task_enabled;
  logic [7:0] task_priority;
  logic task_blocks_lower;
  logic [TW-1:0] task_expiry;
  logic [TW-1:0] now_ms;
  modport source (output valid, op, task_id, task_enabled, task_priority,
    task_blocks_lower, task_expiry, now_ms, input ready);
  modport sink (input valid, op, task_id, task_enabled, task_priority,
    task_blocks_lower, task_expiry, now_ms, output ready);
endinterface

interface ttns_out_if #(parameter int TW = 48) ();
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [7:0] issued_id;
  logic timer_started;
  logic [TW-1:0] wake_time;
  logic [4:0] dropped_count;
  modport source (output valid, kind, issued_id, timer_started, wake_time,
    dropped_count, input ready);
  modport sink (input valid, kind, issued_id, timer_started, wake_time,
    dropped_count, output ready);
endinterface

/* hw/rtl/ttns_cell.sv */
// one table slot; the row rotates left once per cycle during a scan
module ttns_cell import ttns_pkg::*; #(
  parameter int TW = 48
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic                  load_here,
  input  logic                  skip,
  input  logic [META_WIDTH-1:0] load_meta,
  input  logic [TW-1:0]         load_exp,
  input  logic [META_WIDTH-1:0] nb_meta,
  input  logic [TW-1:0]         nb_exp,
  output logic [META_WIDTH-1:0] meta,
  output logic [TW-1:0]         expiry
);
  // payload register: load, rotate, or close up on removal
  always_ff @(posedge clk) begin
    if (ctrl.load && load_here) begin
      meta <= load_meta;
      expiry <= load_exp;
    end else if (ctrl.shift || (ctrl.remove && skip)) begin
      meta <= nb_meta;
      expiry <= nb_exp;
    end
  end
endmodule

/* hw/rtl/task_table_next_task_scheduler_top.sv */
// top level: command sequencer, comparator and row of table cells
// schedule, link, timer and empty-table pop go through ST_DECIDE to ST_OUT
// a pop on a nonempty table first rotates the row one full turn in ST_SCAN
// one command is in work at a time; the next is accepted in the cycle after the take
// synchronous active-high rst clears count, online flag and wake timer
// table contents are not cleared by reset
module task_table_next_task_scheduler_top import ttns_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH = 48
) (
  input logic clk,
  input logic rst,
  ttns_in_if.sink in_ch,
  ttns_out_if.source out_ch
);
`include "assert_macros.svh"
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TIME_WIDTH-1:0] NEVER = '1;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic online, timer_active;
  logic [TIME_WIDTH-1:0] timer_expiry;
  logic [2:0] op;
  logic [TIME_WIDTH-1:0] now;
  logic [META_WIDTH-1:0] cmd_meta;
  logic [TIME_WIDTH-1:0] cmd_exp;
  logic [IW:0] step;
  logic [IW-1:0] best_idx;
  logic [META_WIDTH-1:0] best_meta;
  logic [TIME_WIDTH-1:0] best_exp;
  cell_ctrl_t ctrl;
  logic [META_WIDTH-1:0] c_meta [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] c_exp [TABLE_DEPTH];
  logic wins;
  logic [2:0] r_kind;
  logic [7:0] r_id;
  logic r_started;
  logic [4:0] r_drop;

  // row of cells, cell i takes from cell i+1, last wraps to cell 0
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int NB = (g + 1) % TABLE_DEPTH;
    ttns_cell #(.TW(TIME_WIDTH)) u_cell (
      .clk, .ctrl,
      .load_here(count[IW-1:0] == IW'(g)),
      .skip(IW'(g) >= best_idx),
      .load_meta(cmd_meta), .load_exp(cmd_exp),
      .nb_meta(c_meta[NB]), .nb_exp(c_exp[NB]),
      .meta(c_meta[g]), .expiry(c_exp[g])
    );
  end

  // pairwise rule: candidate at cell 0 against running best
  always_comb begin
    logic le, re, lb, rb, pgt;
    le = best_meta[8]; re = c_meta[0][8];
    lb = best_meta[17]; rb = c_meta[0][17];
    pgt = best_meta[16:9] > c_meta[0][16:9];
    if (!(le && re)) wins = re;
    else if (pgt && rb) wins = 1'b1;
    else if (pgt && lb) wins = 1'b0;
    else if (best_exp <= now && c_exp[0] <= now) wins = pgt;
    else if (best_exp < c_exp[0]) wins = 1'b0;
    else if (c_exp[0] < best_exp) wins = 1'b1;
    else wins = pgt;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and cell control
  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_DECIDE;
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        if (step == (IW+1)'(TABLE_DEPTH - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (op == OP_POP && count != '0 && step == '0) state_next = ST_SCAN;
        else begin
          state_next = ST_OUT;
          ctrl.load = (op == OP_SCHEDULE) && (count < CW'(TABLE_DEPTH));
          ctrl.remove = (op == OP_POP) && (count != '0) && (best_exp <= now);
        end
      end
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);

  // command capture, scan bookkeeping and result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; online <= 1'b0; timer_active <= 1'b0; timer_expiry <= '0;
    end else begin
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          op <= in_ch.op; now <= in_ch.now_ms; step <= '0;
          cmd_meta <= {in_ch.task_blocks_lower, in_ch.task_priority,
                       in_ch.task_enabled, in_ch.task_id};
          cmd_exp <= in_ch.task_expiry;
        end
        ST_SCAN: begin
          if (step == '0 || (IW'(step) < count[IW-1:0] && wins) ||
              (count == CW'(TABLE_DEPTH) && step != '0 && wins)) begin
            if (step == '0 || IW'(step) < count[IW-1:0] ||
                count == CW'(TABLE_DEPTH)) begin
              best_idx <= IW'(step); best_meta <= c_meta[0]; best_exp <= c_exp[0];
            end
          end
          step <= step + 1'b1;
        end
        ST_DECIDE: if (!(op == OP_POP && count != '0 && step == '0)) begin
          r_kind <= KIND_NO_EFFECT; r_id <= '0; r_started <= 1'b0; r_drop <= '0;
          case (op)
            OP_SCHEDULE: if (count < CW'(TABLE_DEPTH)) begin
              count <= count + 1'b1; r_kind <= KIND_ACCEPTED;
            end else r_kind <= KIND_FULL;
            OP_POP: begin
              r_kind <= KIND_NOT_READY;
              if (count != '0) begin
                if (best_exp <= now) begin
                  r_kind <= KIND_ISSUED; r_id <= best_meta[7:0];
                  count <= count - 1'b1;
                end else if (best_exp != NEVER &&
                             (!timer_active || timer_expiry > best_exp)) begin
                  timer_active <= 1'b1; timer_expiry <= best_exp; r_started <= 1'b1;
                end
              end
            end
            OP_LINK_UP: if (!online) begin
              online <= 1'b1; r_kind <= KIND_PENDING;
            end
            OP_LINK_DOWN: if (online) begin
              online <= 1'b0; timer_active <= 1'b0; timer_expiry <= '0;
              r_drop <= 5'(count); count <= '0; r_kind <= KIND_DROPPED;
            end
            OP_TIMER: begin
              timer_active <= 1'b0; timer_expiry <= '0; r_kind <= KIND_PENDING;
            end
            default: r_kind <= KIND_NO_EFFECT;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.kind = r_kind;
  assign out_ch.issued_id = r_id;
  assign out_ch.timer_started = r_started;
  assign out_ch.wake_time = timer_active ? timer_expiry : '0;
  assign out_ch.dropped_count = r_drop;

  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CW'(TABLE_DEPTH))
  `ASSERT_IMPL(a_idle_timer, clk, rst, !timer_active, timer_expiry == '0)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

/* tb/sv/tb_top.sv */
// testbench for the task table scheduler: directed table, then random traffic
module tb_top;
  import ttns_pkg::*;

  localparam int DEPTH = 16;
  localparam int TW = 48;
  localparam logic [TW-1:0] NEVER = {TW{1'b1}};

  typedef struct {
    logic [2:0] op;
    logic [7:0] id;
    logic en;
    logic [7:0] prio;
    logic blk;
    logic [TW-1:0] expiry;
    logic [TW-1:0] now;
  } cmd_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] issued_id;
    logic started;
    logic [TW-1:0] wake;
    logic [4:0] dropped;
  } res_t;

  // directed row: command plus optional typed-in expectation
  typedef struct {
    cmd_t c;
    bit has_exp;
    logic [2:0] kind;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  ttns_in_if #(.TW(TW)) in_ch ();
  ttns_out_if #(.TW(TW)) out_ch ();

  task_table_next_task_scheduler_top #(.TABLE_DEPTH(DEPTH), .TIME_WIDTH(TW)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  cmd_t tbl[DEPTH];
  int unsigned tbl_cnt;
  bit is_online;
  bit wake_armed;
  logic [TW-1:0] wake_at;

  row_t rows[$];
  res_t pending_results[$];
  logic [2:0] typed_kinds[$];
  bit typed_valid[$];
  int mismatches = 0;
  int sender_idle = 0;
  int receiver_idle = 0;

  // append one directed row
  function automatic void add_row(cmd_t c, bit has_exp, logic [2:0] kind);
    rows.insert(rows.size(), '{c, has_exp, kind});
  endfunction

  // candidate r strictly beats running best l
  function automatic bit beats(cmd_t l, cmd_t r, logic [TW-1:0] now);
    if (!(l.en && r.en)) return r.en;
    if (l.prio > r.prio && r.blk) return 1;
    if (l.prio > r.prio && l.blk) return 0;
    if (l.expiry <= now && r.expiry <= now) return l.prio > r.prio;
    if (l.expiry < r.expiry) return 0;
    if (r.expiry < l.expiry) return 1;
    return l.prio > r.prio;
  endfunction

  function automatic res_t schedule_step(cmd_t c);
    res_t r;
    int best;
    r = '{KIND_NO_EFFECT, 8'd0, 1'b0, '0, 5'd0};
    case (c.op)
      OP_SCHEDULE: begin
        if (tbl_cnt < DEPTH) begin
          tbl[tbl_cnt] = c;
          tbl_cnt++;
          r.kind = KIND_ACCEPTED;
        end else begin
          r.kind = KIND_FULL;
        end
      end
      OP_POP: begin
        r.kind = KIND_NOT_READY;
        if (tbl_cnt > 0) begin
          best = 0;
          for (int i = 1; i < tbl_cnt; i++)
            if (beats(tbl[best], tbl[i], c.now)) best = i;
          if (tbl[best].expiry <= c.now) begin
            r.issued_id = tbl[best].id;
            for (int i = best; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
            tbl_cnt--;
            r.kind = KIND_ISSUED;
          end else if (tbl[best].expiry != NEVER) begin
            if (!wake_armed || wake_at > tbl[best].expiry) begin
              wake_armed = 1;
              wake_at = tbl[best].expiry;
              r.started = 1;
            end
          end
        end
      end
      OP_LINK_UP: begin
        if (!is_online) begin
          is_online = 1;
          r.kind = KIND_PENDING;
        end
      end
      OP_LINK_DOWN: begin
        if (is_online) begin
          is_online = 0;
          wake_armed = 0;
          wake_at = '0;
          r.dropped = tbl_cnt[4:0];
          tbl_cnt = 0;
          r.kind = KIND_DROPPED;
        end
      end
      OP_TIMER: begin
        wake_armed = 0;
        wake_at = '0;
        r.kind = KIND_PENDING;
      end
      default: ;
    endcase
    r.wake = wake_armed ? wake_at : '0;
    return r;
  endfunction

  function automatic logic [TW-1:0] rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return NEVER;
      2: return TW'({$urandom, $urandom});
      default: return TW'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) c.op = OP_SCHEDULE;
    else if (pick < 80) c.op = OP_POP;
    else if (pick < 87) c.op = OP_LINK_UP;
    else if (pick < 92) c.op = OP_LINK_DOWN;
    else if (pick < 97) c.op = OP_TIMER;
    else c.op = 3'($urandom_range(5, 7));
    c.id = 8'($urandom);
    c.en = ($urandom_range(0, 3) != 0);
    c.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    c.blk = 1'($urandom_range(0, 1));
    c.expiry = rand_time();
    c.now = rand_time();
    return c;
  endfunction

  // drive one transaction and record its expectation
  task automatic send_cmd(cmd_t c, bit has_exp, logic [2:0] kind);
    while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= c.op;
    in_ch.task_id <= c.id;
    in_ch.task_enabled <= c.en;
    in_ch.task_priority <= c.prio;
    in_ch.task_blocks_lower <= c.blk;
    in_ch.task_expiry <= c.expiry;
    in_ch.now_ms <= c.now;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), schedule_step(c));
    typed_valid.insert(typed_valid.size(), has_exp);
    typed_kinds.insert(typed_kinds.size(), kind);
  endtask

  // receiver stall and result compare
  always @(posedge clk) begin
    res_t e;
    bit bad;
    logic [2:0] tk;
    bit tv;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind=%0d", out_ch.kind);
        end else begin
          e = pending_results.pop_front();
          tk = typed_kinds.pop_front();
          tv = typed_valid.pop_front();
          bad = out_ch.kind !== e.kind || out_ch.issued_id !== e.issued_id ||
                out_ch.timer_started !== e.started || out_ch.wake_time !== e.wake ||
                out_ch.dropped_count !== e.dropped || (tv && out_ch.kind !== tk);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp kind=%0d id=%0d st=%0d wake=%0d drop=%0d",
                        " got %0d %0d %0d %0d %0d"},
                e.kind, e.issued_id, e.started, e.wake, e.dropped, out_ch.kind,
                out_ch.issued_id, out_ch.timer_started, out_ch.wake_time,
                out_ch.dropped_count);
          end
        end
      end
      out_ch.ready <= !(receiver_idle > 0 && $urandom_range(0, 99) < receiver_idle);
    end
  end

  // stimulus
  initial begin
    cmd_t c;
    int wait_cnt;
    in_ch.valid = 0;
    in_ch.op = OP_SCHEDULE;
    in_ch.task_id = 0;
    in_ch.task_enabled = 0;
    in_ch.task_priority = 0;
    in_ch.task_blocks_lower = 0;
    in_ch.task_expiry = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 0;
    tbl_cnt = 0;
    is_online = 0;
    wake_armed = 0;
    wake_at = '0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: empty pop, link edges, undefined op, full table, extremes
    add_row('{OP_POP, 0, 1, 0, 0, '0, '0}, 1, KIND_NOT_READY);
    add_row('{OP_LINK_DOWN, 0, 0, 0, 0, '0, '0}, 1, KIND_NO_EFFECT);
    add_row('{OP_LINK_UP, 0, 0, 0, 0, '0, '0}, 1, KIND_PENDING);
    add_row('{OP_LINK_UP, 0, 0, 0, 0, '0, '0}, 1, KIND_NO_EFFECT);
    add_row('{3'd7, 0, 0, 0, 0, '0, '0}, 1, KIND_NO_EFFECT);
    add_row('{OP_TIMER, 0, 0, 0, 0, '0, '0}, 1, KIND_PENDING);
    add_row('{OP_SCHEDULE, 8'hff, 1, 8'hff, 1, NEVER, '0}, 1, KIND_ACCEPTED);
    add_row('{OP_POP, 0, 0, 0, 0, '0, NEVER - 1}, 1, KIND_NOT_READY);
    add_row('{OP_SCHEDULE, 8'h00, 0, 8'h00, 0, '0, '0}, 1, KIND_ACCEPTED);
    add_row('{OP_SCHEDULE, 8'h5a, 1, 8'h10, 0, 48'd500, '0}, 1, KIND_ACCEPTED);
    add_row('{OP_SCHEDULE, 8'ha5, 1, 8'h01, 0, 48'd300, '0}, 1, KIND_ACCEPTED);
    add_row('{OP_POP, 0, 0, 0, 0, '0, 48'd100}, 0, 0);
    add_row('{OP_SCHEDULE, 8'h33, 1, 8'h00, 0, 48'd200, '0}, 0, 0);
    add_row('{OP_POP, 0, 0, 0, 0, '0, 48'd100}, 0, 0);
    add_row('{OP_POP, 0, 0, 0, 0, '0, NEVER}, 0, 0);
    add_row('{OP_POP, 0, 0, 0, 0, '0, 48'd0}, 0, 0);
    for (int i = 0; i < 13; i++)
      add_row('{OP_SCHEDULE, 8'(i), 1, 8'(i), 0, 48'(1000 + i), '0}, 0, 0);
    add_row('{OP_SCHEDULE, 8'h77, 1, 0, 0, '0, '0}, 1, KIND_FULL);
    add_row('{OP_LINK_DOWN, 0, 0, 0, 0, '0, '0}, 0, 0);
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].has_exp, rows[i].kind);

    // random phases with varying idle pressure
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle = (ph == 0) ? 21 : (ph == 1) ? 67 : 0;
      receiver_idle = (ph == 0) ? 67 : (ph == 1) ? 21 : 0;
      for (int n = 0; n < 330; n++) begin
        c = rand_cmd();
        send_cmd(c, 0, 0);
      end
    end
    in_ch.valid <= 0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
